FILE: hdl/imubc_pkg.sv
// ----------------------------------------------------------------------------
// imubc_pkg
// Shared types and constants for the imu bias calibrate and correct block:
// axis layout, sum width, register map, controller states and the
// command and status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package imubc_pkg;

   // frame layout
   localparam int NUM_AXES   = 6;
   localparam int AXIS_W     = 16;
   localparam int AXIS_IDX_W = 3;
   localparam logic [AXIS_IDX_W-1:0] AXIS_ACCEL_Z = 3'd2;
   localparam logic [AXIS_IDX_W-1:0] AXIS_LAST    = 3'd5;

   // running sums wrap at this width
   localparam int SUM_W  = 25;
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] STEP_LAST = 5'(SUM_W - 1);

   // configuration registers
   localparam int COUNT_REG_W = 9;
   localparam int GRAV_W      = 15;
   localparam logic [COUNT_REG_W-1:0] SAMPLE_COUNT_RESET = 9'd200;
   localparam logic [GRAV_W-1:0]      GRAVITY_RESET      = 15'd16384;
   localparam logic REG_SAMPLE_COUNT = 1'b0;
   localparam logic REG_GRAVITY      = 1'b1;

   // frame and result kinds
   localparam logic FRAME_CAL   = 1'b0;
   localparam logic FRAME_DATA  = 1'b1;
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_OFFSET = 1'b1;

   typedef logic [NUM_AXES-1:0][AXIS_W-1:0] axes_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV_LOAD,
      ST_DIV_STEP,
      ST_DIV_STORE,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic                  capture;
      logic                  accumulate;
      logic                  clear_wrap;
      logic                  div_load;
      logic                  div_step;
      logic                  div_store;
      logic                  load_data;
      logic                  load_offsets;
      logic [AXIS_IDX_W-1:0] axis;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_data;
      logic cal_done;
      logic out_free;
   } dpath_status_type;

endpackage

FILE: hdl/imubc_ctrl.sv
// ----------------------------------------------------------------------------
// imubc_ctrl
// Controller: sequences capture, accumulation, the per-axis bit-serial
// division of the sums and the loading of the output register.
// ----------------------------------------------------------------------------
module imubc_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  imubc_pkg::dpath_status_type status,
   output imubc_pkg::ctrl_cmd_type     cmd
);
   import imubc_pkg::*;

   ctrl_state_type        state_ff, state_in;
   logic [AXIS_IDX_W-1:0] axis_ff, axis_in;
   logic [STEP_W-1:0]     step_ff, step_in;

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         step_ff  <= step_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.is_data) begin
               if (status.out_free) begin
                  state_in = ST_IDLE;
               end
            end else if (status.cal_done) begin
               state_in = ST_DIV_LOAD;
               axis_in  = '0;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV_LOAD: begin
            state_in = ST_DIV_STEP;
            step_in  = '0;
         end
         ST_DIV_STEP: begin
            if (step_ff == STEP_LAST) begin
               state_in = ST_DIV_STORE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DIV_STORE: begin
            if (axis_ff == AXIS_LAST) begin
               state_in = ST_EMIT;
               axis_in  = '0;
            end else begin
               state_in = ST_DIV_LOAD;
               axis_in  = axis_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd        = '0;
      cmd.axis   = axis_ff;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_EXEC: begin
            if (status.is_data) begin
               cmd.load_data = status.out_free;
            end else begin
               cmd.accumulate = 1'b1;
               cmd.clear_wrap = status.cal_done;
            end
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
         end
         ST_DIV_STEP: begin
            cmd.div_step = 1'b1;
         end
         ST_DIV_STORE: begin
            cmd.div_store = 1'b1;
         end
         ST_EMIT: begin
            cmd.load_offsets = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: hdl/imubc_dpath.sv
// ----------------------------------------------------------------------------
// imubc_dpath
// Datapath: input frame register, running sums, frame counter, a shared
// restoring divider (one quotient bit per cycle), offsets and the output
// register.
// ----------------------------------------------------------------------------
module imubc_dpath #(
   parameter int MAX_CAL_SAMPLES = 256
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  imubc_pkg::ctrl_cmd_type                 cmd,
   output imubc_pkg::dpath_status_type             status,
   input  logic [imubc_pkg::COUNT_REG_W-1:0]       sample_count,
   input  logic [imubc_pkg::GRAV_W-1:0]            gravity_counts,
   input  logic                                    in_type,
   input  imubc_pkg::axes_type                     in_axes,
   input  logic [imubc_pkg::AXIS_W-1:0]            in_temp,
   input  logic                                    rsp_tready,
   output logic                                    rsp_valid,
   output logic                                    rsp_kind,
   output imubc_pkg::axes_type                     rsp_axes,
   output logic [imubc_pkg::AXIS_W-1:0]            rsp_temp,
   output logic                                    rsp_wrapped
);
   import imubc_pkg::*;

   // largest count the register can ask for under the limit
   localparam int CLAMP = (MAX_CAL_SAMPLES < (2 ** COUNT_REG_W) - 1) ?
                          MAX_CAL_SAMPLES : (2 ** COUNT_REG_W) - 1;
   localparam int CNT_W = (CLAMP < 2) ? 1 : $clog2(CLAMP + 1);
   localparam int AVG_W = SUM_W + 2;

   // input frame register
   logic                  type_ff;
   axes_type              samp_ff;
   logic [AXIS_W-1:0]     temp_ff;

   // calibration state
   logic [SUM_W-1:0]      sums_ff [NUM_AXES];
   axes_type              offs_ff;
   logic [CNT_W-1:0]      frames_ff;
   logic                  wrap_ff;

   // divider
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [SUM_W-1:0]      quo_ff, quo_in;
   logic                  neg_ff;

   // output register
   logic                  valid_ff;
   logic                  kind_ff;
   axes_type              axes_ff;
   logic [AXIS_W-1:0]     otemp_ff;
   logic                  owrap_ff;

   logic [CNT_W-1:0]      eff_count;
   logic [CNT_W:0]        frames_next;
   logic [SUM_W-1:0]      sel_sum;
   logic [SUM_W-1:0]      sel_mag;
   logic [CNT_W:0]        rem_shift;
   logic [SUM_W:0]        quo_signed;
   logic [AVG_W-1:0]      avg;
   logic                  avg_wrap;
   axes_type              corr;
   logic [NUM_AXES-1:0]   corr_wrap;
   logic                  out_free;

   // effective calibration count, zero acts as one
   always_comb begin
      if (sample_count == '0) begin
         eff_count = CNT_W'(1);
      end else if (sample_count > COUNT_REG_W'(CLAMP)) begin
         eff_count = CNT_W'(CLAMP);
      end else begin
         eff_count = sample_count[CNT_W-1:0];
      end
   end

   assign frames_next = {1'b0, frames_ff} + 1'b1;
   assign out_free    = !valid_ff || rsp_tready;

   assign status.is_data  = (type_ff == FRAME_DATA);
   assign status.cal_done = (frames_next >= {1'b0, eff_count});
   assign status.out_free = out_free;

   // divider operand selection and one restoring step
   always_comb begin
      sel_sum   = sums_ff[cmd.axis];
      sel_mag   = sel_sum[SUM_W-1] ? (~sel_sum + 1'b1) : sel_sum;
      rem_shift = {rem_ff, quo_ff[SUM_W-1]};
      if (rem_shift >= {1'b0, eff_count}) begin
         rem_in = CNT_W'(rem_shift - {1'b0, eff_count});
         quo_in = {quo_ff[SUM_W-2:0], 1'b1};
      end else begin
         rem_in = rem_shift[CNT_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], 1'b0};
      end
   end

   // signed average, gravity taken off the z accelerometer
   always_comb begin
      quo_signed = neg_ff ? (~{1'b0, quo_ff} + 1'b1) : {1'b0, quo_ff};
      avg        = {quo_signed[SUM_W], quo_signed};
      if (cmd.axis == AXIS_ACCEL_Z) begin
         avg = avg - {{(AVG_W-GRAV_W){1'b0}}, gravity_counts};
      end
      avg_wrap = (avg[AVG_W-1:AXIS_W-1] != {(AVG_W-AXIS_W+1){avg[AXIS_W-1]}});
   end

   // corrected samples for a data frame
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         logic [AXIS_W:0] diff;
         diff = {samp_ff[i][AXIS_W-1], samp_ff[i]} - {offs_ff[i][AXIS_W-1], offs_ff[i]};
         corr[i]      = diff[AXIS_W-1:0];
         corr_wrap[i] = diff[AXIS_W] != diff[AXIS_W-1];
      end
   end

   // frame capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff <= in_type;
         samp_ff <= in_axes;
         temp_ff <= in_temp;
      end
   end

   // sums, counter and offsets
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            sums_ff[i] <= '0;
         end
         offs_ff   <= '0;
         frames_ff <= '0;
         wrap_ff   <= 1'b0;
      end else begin
         if (cmd.accumulate) begin
            for (int i = 0; i < NUM_AXES; i++) begin
               sums_ff[i] <= sums_ff[i] +
                             {{(SUM_W-AXIS_W){samp_ff[i][AXIS_W-1]}}, samp_ff[i]};
            end
            frames_ff <= status.cal_done ? '0 : frames_next[CNT_W-1:0];
         end
         if (cmd.clear_wrap) begin
            wrap_ff <= 1'b0;
         end
         if (cmd.div_store) begin
            offs_ff[cmd.axis] <= avg[AXIS_W-1:0];
            sums_ff[cmd.axis] <= '0;
            wrap_ff           <= wrap_ff | avg_wrap;
         end
      end
   end

   // divider registers
   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff <= '0;
         quo_ff <= sel_mag;
         neg_ff <= sel_sum[SUM_W-1];
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.load_data || cmd.load_offsets) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (cmd.load_data) begin
         kind_ff  <= KIND_DATA;
         axes_ff  <= corr;
         otemp_ff <= temp_ff;
         owrap_ff <= |corr_wrap;
      end else if (cmd.load_offsets) begin
         kind_ff  <= KIND_OFFSET;
         axes_ff  <= offs_ff;
         otemp_ff <= '0;
         owrap_ff <= wrap_ff;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_kind    = kind_ff;
   assign rsp_axes    = axes_ff;
   assign rsp_temp    = otemp_ff;
   assign rsp_wrapped = owrap_ff;

endmodule

FILE: hdl/imu_bias_calibrate_and_correct.sv
// ----------------------------------------------------------------------------
// imu_bias_calibrate_and_correct
// Six-axis imu bias calibration and correction with a register port for the
// calibration count and the one-g count.
// ----------------------------------------------------------------------------
// Usage:
// Frames arrive on the req stream: tuser selects a calibration frame (0) or
// a data frame (1); tdata carries accel x/y/z, gyro x/y/z and temperature.
// Words leave on the rsp stream: tuser is the result kind (0 corrected data,
// 1 new offsets), tdata the six axes, temperature and the wrap flag.
// One frame is handled at a time. A data frame or a calibration frame that
// does not complete the count is captured and passes through the execute
// state before the next ready; a data frame's word is loaded into the output
// register from that state. The frame that completes the count runs the
// shared bit-serial divider over the six sums, one axis after another
// through load, step and store, and then its offset word is loaded.
// A finished word waits in the output register; the next frame is taken
// meanwhile, and the block holds only when a second word is ready before the
// first was taken. Reset clears sums, offsets, counter and the output valid,
// and loads the register defaults (count 200, one g 16384).
// ----------------------------------------------------------------------------
module imu_bias_calibrate_and_correct #(
   parameter int MAX_CAL_SAMPLES = 256
) (
   input  logic         clock,
   input  logic         reset,
   // request stream
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata,  // accel_x_in, accel_y_in, accel_z_in,
                                    // gyro_x_in, gyro_y_in, gyro_z_in, temp_in
   input  logic         req_tuser,  // req_type
   // response stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,  // accel_x_out, accel_y_out, accel_z_out,
                                    // gyro_x_out, gyro_y_out, gyro_z_out,
                                    // temp_out, wrapped, zero fill
   output logic         rsp_tuser,  // result_kind
   // register port
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import imubc_pkg::*;

   logic [COUNT_REG_W-1:0] sample_count_ff;
   logic [GRAV_W-1:0]      gravity_ff;
   logic                   csr_write;

   ctrl_cmd_type           cmd;
   dpath_status_type       status;
   axes_type               in_axes;
   axes_type               out_axes;
   logic [AXIS_W-1:0]      out_temp;
   logic                   out_wrapped;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= SAMPLE_COUNT_RESET;
         gravity_ff      <= GRAVITY_RESET;
      end else if (csr_write) begin
         case (csr_paddr[2])
            REG_SAMPLE_COUNT: sample_count_ff <= csr_pwdata[COUNT_REG_W-1:0];
            REG_GRAVITY:      gravity_ff      <= csr_pwdata[GRAV_W-1:0];
            default: begin
               sample_count_ff <= sample_count_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_SAMPLE_COUNT: csr_prdata = {{(32-COUNT_REG_W){1'b0}}, sample_count_ff};
         REG_GRAVITY:      csr_prdata = {{(32-GRAV_W){1'b0}}, gravity_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // unpack the request word
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         in_axes[i] = req_tdata[i*AXIS_W +: AXIS_W];
      end
   end

   imubc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   imubc_dpath #(
      .MAX_CAL_SAMPLES (MAX_CAL_SAMPLES)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .sample_count   (sample_count_ff),
      .gravity_counts (gravity_ff),
      .in_type        (req_tuser),
      .in_axes        (in_axes),
      .in_temp        (req_tdata[NUM_AXES*AXIS_W +: AXIS_W]),
      .rsp_tready     (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .rsp_kind       (rsp_tuser),
      .rsp_axes       (out_axes),
      .rsp_temp       (out_temp),
      .rsp_wrapped    (out_wrapped)
   );

   // pack the response word
   always_comb begin
      rsp_tdata = '0;
      for (int i = 0; i < NUM_AXES; i++) begin
         rsp_tdata[i*AXIS_W +: AXIS_W] = out_axes[i];
      end
      rsp_tdata[NUM_AXES*AXIS_W +: AXIS_W] = out_temp;
      rsp_tdata[(NUM_AXES+1)*AXIS_W]       = out_wrapped;
   end

endmodule
